// ----- hdl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, opcodes and the controller state type.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Default number of physical pages tracked by the bitmap.
  localparam int NUM_PAGES_DEF = 4096;

  // Pages held in one bitmap memory word, and its log2.
  localparam int WORD_W  = 8;
  localparam int WORD_SH = 3;

  // Field widths of the request, result and limit register.
  localparam int CNT_W   = 13;
  localparam int START_W = 12;
  localparam int PAGE_W  = 12;
  localparam int LIMIT_W = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK,
    ST_RESULT
  } state_t;

endpackage

// ----- hdl/bpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bpa_scan.sv -----
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Extends the free-run count across one bitmap word and reports the first
// page of a run that reaches the requested length.
// ----------------------------------------------------------------------------
module bpa_scan #(
  parameter int EXT_W = 14
) (
  input  logic [bpa_pkg::WORD_W-1:0] data,
  input  logic [EXT_W-1:0]           base,
  input  logic [EXT_W-1:0]           span,
  input  logic [bpa_pkg::CNT_W-1:0]  count,
  input  logic [bpa_pkg::CNT_W-1:0]  run_in,
  output logic                       found,
  output logic [EXT_W-1:0]           first,
  output logic [bpa_pkg::CNT_W-1:0]  run_out,
  output logic                       at_end
);

  logic [EXT_W-1:0]          p;
  logic [bpa_pkg::CNT_W-1:0] run_v;
  logic                      stop;

  always_comb begin
    run_v = run_in;
    found = 1'b0;
    stop  = 1'b0;
    first = '0;
    p     = base;
    for (int b = 0; b < bpa_pkg::WORD_W; b++) begin
      p = base + EXT_W'(b);
      if (!found && !stop) begin
        if (p >= span) begin
          stop = 1'b1;
        end else if (!data[b]) begin
          run_v = run_v + 1'b1;
          if (run_v == count) begin
            found = 1'b1;
            first = p + EXT_W'(1) - EXT_W'(count);
          end
        end else begin
          run_v = '0;
        end
      end
    end
    run_out = run_v;
    at_end  = (base + EXT_W'(bpa_pkg::WORD_W)) >= span;
  end

endmodule

// ----- hdl/bpa_mark.sv -----
// ----------------------------------------------------------------------------
// Bitmap word marker
// Sets or clears the bits of one bitmap word whose pages lie in [lo, hi).
// ----------------------------------------------------------------------------
module bpa_mark #(
  parameter int EXT_W = 14
) (
  input  logic [bpa_pkg::WORD_W-1:0] data,
  input  logic [EXT_W-1:0]           base,
  input  logic [EXT_W-1:0]           lo,
  input  logic [EXT_W-1:0]           hi,
  input  logic                       set,
  output logic [bpa_pkg::WORD_W-1:0] wdata
);

  logic [bpa_pkg::WORD_W-1:0] mask;

  always_comb begin
    for (int b = 0; b < bpa_pkg::WORD_W; b++) begin
      mask[b] = ((base + EXT_W'(b)) >= lo) && ((base + EXT_W'(b)) < hi);
    end
    wdata = set ? (data | mask) : (data & ~mask);
  end

endmodule

// ----- hdl/bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit contiguous page allocator over a one-bit-per-page used bitmap.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of 8-page words. After reset a clearing pass
// marks every page used, writing one word per cycle; requests are held off
// until it ends, but limit writes are taken at any time. An allocate request
// scans the words from page 0 upward, one word per cycle, over a span of
// min(limit_pages, NUM_PAGES) pages, and stops early when a run is found. A
// successful allocate then rewrites the words of the run, one per cycle, and
// a free request rewrites the words of its range in the same way. One request
// is worked on at a time; a new request is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core #(
  parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // Limit register write port.
  input  logic                         cfg_wr_en,
  input  logic [bpa_pkg::LIMIT_W-1:0]  cfg_wr_data,
  // Request channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [bpa_pkg::START_W-1:0]  start_page,
  input  logic [bpa_pkg::CNT_W-1:0]    page_count,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         success,
  output logic [bpa_pkg::PAGE_W-1:0]   found_page
);

  // Page arithmetic is carried at a width that holds NUM_PAGES itself and
  // the sum of a start page and a count.
  localparam int NP_W   = $clog2(NUM_PAGES + 1);
  localparam int EXT_W  = ((NP_W > bpa_pkg::CNT_W) ? NP_W : bpa_pkg::CNT_W) + 1;
  localparam int WIDX_W = EXT_W - bpa_pkg::WORD_SH;
  localparam int RAM_DEPTH = (NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam logic [EXT_W-1:0] NP_EXT = EXT_W'(NUM_PAGES);

  bpa_pkg::state_t state, state_next;

  // Limit register.
  logic [bpa_pkg::LIMIT_W-1:0] limit_pages;

  // Latched request.
  logic                         op, op_next;
  logic [bpa_pkg::START_W-1:0]  start, start_next;
  logic [bpa_pkg::CNT_W-1:0]    count, count_next;

  // Working registers.
  logic [EXT_W-1:0]             span, span_next;
  logic [EXT_W-1:0]             lo, lo_next;
  logic [EXT_W-1:0]             hi, hi_next;
  logic [WIDX_W-1:0]            widx, widx_next;
  logic [bpa_pkg::CNT_W-1:0]    run, run_next;
  logic [RAM_AW-1:0]            clr_idx, clr_idx_next;

  // Pending result and output register.
  logic                         res_ok, res_ok_next;
  logic [bpa_pkg::PAGE_W-1:0]   res_page, res_page_next;
  logic                         out_valid_next;
  logic                         success_next;
  logic [bpa_pkg::PAGE_W-1:0]   found_page_next;

  // Memory ports.
  logic                         ram_we, ram_re;
  logic [RAM_AW-1:0]            ram_waddr, ram_raddr;
  logic [bpa_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;

  // Scanner and marker.
  logic [EXT_W-1:0]             word_base;
  logic                         scan_found, scan_end;
  logic [EXT_W-1:0]             scan_first;
  logic [bpa_pkg::CNT_W-1:0]    scan_run;
  logic [bpa_pkg::WORD_W-1:0]   mark_wdata;

  // Decode helpers.
  logic [EXT_W-1:0]             limit_ext, span_calc, start_ext, free_end;
  logic [WIDX_W-1:0]            widx_inc;

  assign word_base = {widx, {bpa_pkg::WORD_SH{1'b0}}};
  assign widx_inc  = widx + 1'b1;
  assign in_ready  = (state == bpa_pkg::ST_IDLE);

  bpa_ram #(
    .WIDTH (bpa_pkg::WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpa_scan #(
    .EXT_W (EXT_W)
  ) u_scan (
    .data    (ram_rdata),
    .base    (word_base),
    .span    (span),
    .count   (count),
    .run_in  (run),
    .found   (scan_found),
    .first   (scan_first),
    .run_out (scan_run),
    .at_end  (scan_end)
  );

  // Allocation sets the run's bits, a free clears them.
  bpa_mark #(
    .EXT_W (EXT_W)
  ) u_mark (
    .data  (ram_rdata),
    .base  (word_base),
    .lo    (lo),
    .hi    (hi),
    .set   (op == bpa_pkg::OP_ALLOC),
    .wdata (mark_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bpa_pkg::ST_CLEAR;
      limit_pages <= bpa_pkg::LIMIT_RESET;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        limit_pages <= cfg_wr_data;
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    op         <= op_next;
    start      <= start_next;
    count      <= count_next;
    span       <= span_next;
    lo         <= lo_next;
    hi         <= hi_next;
    widx       <= widx_next;
    run        <= run_next;
    res_ok     <= res_ok_next;
    res_page   <= res_page_next;
    success    <= success_next;
    found_page <= found_page_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    start_next      = start;
    count_next      = count;
    span_next       = span;
    lo_next         = lo;
    hi_next         = hi;
    widx_next       = widx;
    run_next        = run;
    clr_idx_next    = clr_idx;
    res_ok_next     = res_ok;
    res_page_next   = res_page;
    out_valid_next  = out_valid && !out_ready;
    success_next    = success;
    found_page_next = found_page;

    ram_we    = 1'b0;
    ram_waddr = widx[RAM_AW-1:0];
    ram_wdata = mark_wdata;
    ram_re    = 1'b0;
    ram_raddr = widx_inc[RAM_AW-1:0];

    // The search never looks past the end of the store.
    limit_ext = EXT_W'(limit_pages);
    span_calc = (limit_ext > NP_EXT) ? NP_EXT : limit_ext;
    start_ext = EXT_W'(start);
    free_end  = start_ext + EXT_W'(count);
    if (free_end > NP_EXT) begin
      free_end = NP_EXT;
    end

    case (state)
      bpa_pkg::ST_CLEAR: begin
        // Mark every page used, one word per cycle.
        ram_we       = 1'b1;
        ram_waddr    = clr_idx;
        ram_wdata    = '1;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == RAM_AW'(RAM_DEPTH - 1)) begin
          state_next = bpa_pkg::ST_IDLE;
        end
      end

      bpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_next    = opcode;
          start_next = start_page;
          count_next = page_count;
          state_next = bpa_pkg::ST_DECODE;
        end
      end

      bpa_pkg::ST_DECODE: begin
        span_next = span_calc;
        if (op == bpa_pkg::OP_ALLOC) begin
          if ((count == '0) || (span_calc == '0)) begin
            // Zero-length request or empty search window.
            res_ok_next   = 1'b0;
            res_page_next = '0;
            state_next    = bpa_pkg::ST_RESULT;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            widx_next  = '0;
            run_next   = '0;
            state_next = bpa_pkg::ST_SCAN;
          end
        end else begin
          res_ok_next   = 1'b1;
          res_page_next = '0;
          if ((count == '0) || (start_ext >= NP_EXT)) begin
            // Nothing inside the store to clear.
            state_next = bpa_pkg::ST_RESULT;
          end else begin
            lo_next    = start_ext;
            hi_next    = free_end;
            state_next = bpa_pkg::ST_MARK_RD;
          end
        end
      end

      bpa_pkg::ST_SCAN: begin
        // The word read last cycle is in ram_rdata; fetch the next one.
        if (scan_found) begin
          lo_next       = scan_first;
          hi_next       = scan_first + EXT_W'(count);
          res_ok_next   = 1'b1;
          res_page_next = scan_first[bpa_pkg::PAGE_W-1:0];
          state_next    = bpa_pkg::ST_MARK_RD;
        end else if (scan_end) begin
          res_ok_next   = 1'b0;
          res_page_next = '0;
          state_next    = bpa_pkg::ST_RESULT;
        end else begin
          run_next  = scan_run;
          widx_next = widx_inc;
          ram_re    = 1'b1;
        end
      end

      bpa_pkg::ST_MARK_RD: begin
        widx_next  = lo[EXT_W-1:bpa_pkg::WORD_SH];
        ram_re     = 1'b1;
        ram_raddr  = lo[bpa_pkg::WORD_SH +: RAM_AW];
        state_next = bpa_pkg::ST_MARK;
      end

      bpa_pkg::ST_MARK: begin
        // Read-modify-write one word per cycle; the next read goes to a
        // different word, so no forwarding is needed.
        ram_we = 1'b1;
        if ({widx_inc, {bpa_pkg::WORD_SH{1'b0}}} >= hi) begin
          state_next = bpa_pkg::ST_RESULT;
        end else begin
          widx_next = widx_inc;
          ram_re    = 1'b1;
        end
      end

      bpa_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          success_next    = res_ok;
          found_page_next = res_page;
          state_next      = bpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests through the valid/ready channels with
// random idle gaps and result stalls. A bit-accurate shadow of the page bitmap
// predicts every result, and each result is checked as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_PAGES      = bpa_pkg::NUM_PAGES_DEF;
  localparam int PAGE_W         = bpa_pkg::PAGE_W;
  localparam int CNT_W          = bpa_pkg::CNT_W;
  localparam int START_W        = bpa_pkg::START_W;
  localparam int LIMIT_W        = bpa_pkg::LIMIT_W;
  // Cycles with no handshake on either channel before the run is abandoned.
  // The limit lies well above the slowest request (a full-store allocate),
  // the clearing pass after reset and the longest gap or stall.
  localparam int WATCHDOG_LIMIT = 20000;
  // Quiet cycles after the last result, to catch anything spurious.
  localparam int TAIL_CYCLES    = 64;

  typedef struct packed {
    logic              success;
    logic [PAGE_W-1:0] page;
  } alloc_result_t;

  // An allocated run that random traffic may hand back later.
  typedef struct packed {
    logic [PAGE_W-1:0] first;
    logic [CNT_W-1:0]  count;
  } page_run_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 opcode      = bpa_pkg::OP_ALLOC;
  logic [START_W-1:0]   start_page  = '0;
  logic [CNT_W-1:0]     page_count  = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic                 success;
  logic [PAGE_W-1:0]    found_page;

  // Shadow of the block: the used bitmap and the search limit.
  bit                   page_map [NUM_PAGES];
  logic [LIMIT_W-1:0]   limit_shadow;

  alloc_result_t        expected_results [$];
  page_run_t            live_runs [$];

  int                   error_count = 0;
  int                   idle_cycles = 0;
  int                   next_gap    = 1;
  int                   stall_left  = 0;
  // When set, neither side inserts gaps or stalls.
  bit                   quiet       = 1'b0;

  bitmap_page_allocator_core #(
    .NUM_PAGES(NUM_PAGES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .start_page (start_page),
    .page_count (page_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .success    (success),
    .found_page (found_page)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length for either side: mostly none or short, a few long ones.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 80);
  endfunction

  // Applies one request to the shadow bitmap and returns the result the block
  // must produce. A free clears bits up to the end of the store and never
  // wraps. An allocate is a first-fit search below the limit, clipped to the
  // store size; a zero count or no fitting run leaves the bitmap untouched.
  function automatic alloc_result_t predict_request(input logic op,
                                                    input logic [START_W-1:0] start,
                                                    input logic [CNT_W-1:0] count);
    alloc_result_t res;
    int span;
    int run;
    int first;
    res   = '0;
    first = -1;
    if (op == bpa_pkg::OP_FREE) begin
      for (int k = 0; k < count; k++) begin
        if (start + k >= NUM_PAGES) break;
        page_map[start + k] = 1'b0;
      end
      res.success = 1'b1;
    end else if (count != 0) begin
      span = (limit_shadow > NUM_PAGES) ? NUM_PAGES : limit_shadow;
      run  = 0;
      for (int i = 0; i < span; i++) begin
        if (!page_map[i]) begin
          run++;
          if (run == count) begin
            first = i + 1 - count;
            break;
          end
        end else begin
          run = 0;
        end
      end
      if (first >= 0) begin
        for (int k = 0; k < count; k++) page_map[first + k] = 1'b1;
        res.success = 1'b1;
        res.page    = first[PAGE_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Presents one request and holds it until the block takes it. The gap before
  // the next request is chosen at acceptance: with no gap, valid simply stays
  // high and the next call changes the payload in the same step, so valid is
  // never lowered and raised again within one edge.
  task automatic send_request(input logic op, input logic [START_W-1:0] start,
                              input logic [CNT_W-1:0] count);
    alloc_result_t want;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_valid   <= 1'b1;
    opcode     <= op;
    start_page <= start;
    page_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_request(op, start, count);
    expected_results.push_back(want);
    if (op == bpa_pkg::OP_ALLOC && want.success)
      live_runs.push_back('{first: want.page, count: count});
    next_gap = pick_gap();
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // Lowers a held valid and waits until every predicted result has come out.
  // Every request yields exactly one result, so an empty queue means idle.
  task automatic wait_idle();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes the limit register while the block has nothing in flight.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    limit_shadow = value;
  endtask

  // Every page is used after reset, so nothing can be allocated yet. The
  // reset limit covers the whole store, so the first allocate scans it all.
  task automatic test_reset_state();
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd0);
    send_request(bpa_pkg::OP_FREE, 12'd4095, 13'd0);
  endtask

  // Basic first-fit behavior: zero-length allocate, a request too long for
  // any free run, refreeing pages that are already free, and a free that
  // runs past the last page of the store.
  task automatic test_alloc_free_basics();
    send_request(bpa_pkg::OP_FREE, 12'd0, 13'd64);
    send_request(bpa_pkg::OP_ALLOC, 12'hfff, 13'd1);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd4);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd0);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd100);
    send_request(bpa_pkg::OP_FREE, 12'd1, 13'd4);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd3);
    send_request(bpa_pkg::OP_FREE, 12'd32, 13'd8);
    send_request(bpa_pkg::OP_FREE, 12'd4090, 13'd20);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd6);
  endtask

  // Limit extremes: zero blocks all allocation, a small limit hides the rest
  // of the store, the full store can be taken in one run, a limit one short
  // of the store refuses it, and a limit above the store is clipped.
  task automatic test_limit_settings();
    write_limit(13'd0);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
    write_limit(13'd8);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd2);
    write_limit(13'd4096);
    send_request(bpa_pkg::OP_FREE, 12'd0, 13'd4096);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd4096);
    send_request(bpa_pkg::OP_FREE, 12'd4095, 13'd1);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
    write_limit(13'd4095);
    send_request(bpa_pkg::OP_FREE, 12'd0, 13'd4096);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd4096);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd4095);
    write_limit(13'd5000);
    send_request(bpa_pkg::OP_ALLOC, 12'd0, 13'd1);
  endtask

  // Random traffic in phases of different limits. Most requests follow a
  // plausible pattern: allocate short runs, return runs that were handed out
  // earlier, and free scattered regions below the limit so that later
  // allocations find holes. The rest is noise: zero counts, huge counts and
  // frees that start anywhere in the store.
  task automatic test_random_traffic();
    logic [LIMIT_W-1:0] phase_limits [9];
    logic [LIMIT_W-1:0] lim;
    logic [CNT_W-1:0]   cnt;
    page_run_t          victim;
    int                 span;
    int                 pick;
    int                 sel;
    int                 idx;
    phase_limits = '{13'd16, 13'd256, 13'd4096, 13'd1, 13'd100,
                     13'd2048, 13'd37, 13'd4095, 13'd0};
    for (int p = 0; p < 9; p++) begin
      lim = (p == 8) ? LIMIT_W'($urandom_range(2, 4096)) : phase_limits[p];
      write_limit(lim);
      span = (lim > NUM_PAGES) ? NUM_PAGES : int'(lim);
      for (int n = 0; n < 155; n++) begin
        // Now and then a stretch with no gaps or stalls at all.
        if (n % 40 == 0) quiet = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        if (pick < 45) begin
          if (sel < 70)      cnt = CNT_W'($urandom_range(1, (span < 16) ? span : 16));
          else if (sel < 92) cnt = CNT_W'($urandom_range(1, span));
          else if (sel < 96) cnt = '0;
          else               cnt = CNT_W'($urandom_range(0, 4096));
          // The start field is ignored by allocate, so it carries random bits.
          send_request(bpa_pkg::OP_ALLOC, START_W'($urandom), cnt);
        end else if (pick < 75 && live_runs.size() > 0) begin
          idx    = $urandom_range(0, live_runs.size() - 1);
          victim = live_runs[idx];
          live_runs.delete(idx);
          send_request(bpa_pkg::OP_FREE, victim.first, victim.count);
        end else if (pick < 90) begin
          send_request(bpa_pkg::OP_FREE, START_W'($urandom_range(0, span - 1)),
                       CNT_W'($urandom_range(1, 32)));
        end else begin
          if (sel < 60)      cnt = CNT_W'($urandom_range(0, 64));
          else if (sel < 75) cnt = 13'd4096;
          else if (sel < 90) cnt = '0;
          else               cnt = CNT_W'($urandom_range(0, 4096));
          send_request((sel < 50) ? bpa_pkg::OP_FREE : bpa_pkg::OP_ALLOC,
                       START_W'($urandom), cnt);
        end
      end
      quiet = 1'b0;
    end
  endtask

  // Result side: random stalls on out_ready, driven once per edge.
  always @(posedge clk) begin : result_sink
    int stall;
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall = pick_gap();
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = stall - 1;
      end
    end
  end

  // Each result taken by the sink is compared with the oldest prediction.
  // Both handshake signals are read before the edge updates them.
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: success=%0b page=%0d",
                                  success, found_page));
      end else begin
        want = expected_results.pop_front();
        if (success !== want.success)
          report_mismatch($sformatf("success %0b, predicted %0b", success, want.success));
        if (found_page !== want.page)
          report_mismatch($sformatf("found_page %0d, predicted %0d", found_page, want.page));
      end
    end
  end

  // The run is abandoned if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_PAGES; i++) page_map[i] = 1'b1;
    limit_shadow = bpa_pkg::LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_alloc_free_basics();
    test_limit_settings();
    test_random_traffic();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
